[design/assert_macros.svh]
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/mipsc_pkg.sv]
// Shared constants and types for the MIPS integer core subset.
`default_nettype none
package mipsc_pkg;

    localparam int XLEN    = 32;
    localparam int AW      = 29;
    localparam int NREG    = 32;
    localparam int RIDX_W  = 5;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 96;
    localparam int MOP_W   = 2;

    // output tdata field positions
    localparam int FA_LO = 0;
    localparam int MA_LO = 29;
    localparam int WD_LO = 58;
    localparam int LW_BIT = 90;

    localparam logic [31:0] RESET_PC  = 32'hBFC0_0000;
    localparam logic [31:0] JUMP_MASK = 32'hF000_0000;

    localparam logic [1:0] MOP_NONE  = 2'd0;
    localparam logic [1:0] MOP_READ  = 2'd1;
    localparam logic [1:0] MOP_WRITE = 2'd2;

    localparam logic KIND_INSTR = 1'b0;
    localparam logic KIND_LOAD  = 1'b1;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // SPECIAL functions
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_SRA  = 6'h03;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_JALR = 6'h09;
    localparam logic [5:0] FN_MFHI = 6'h10;
    localparam logic [5:0] FN_MFLO = 6'h12;
    localparam logic [5:0] FN_MULT = 6'h18;
    localparam logic [5:0] FN_DIV  = 6'h1A;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_XOR  = 6'h26;
    localparam logic [5:0] FN_SLT  = 6'h2A;
    localparam logic [5:0] FN_SLTU = 6'h2B;

    localparam logic [4:0] RT_BLTZ = 5'h00;
    localparam logic [4:0] RT_BGEZ = 5'h01;
    localparam logic [4:0] C0_MFC0 = 5'h00;
    localparam logic [4:0] C0_MTC0 = 5'h04;
    localparam logic [4:0] REG_RA  = 5'd31;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FIX  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

endpackage
`default_nettype wire

[design/mips_integer_core_subset.sv]
// Top level: sequenced MIPS integer core subset with a shared mul/div step unit.
`default_nettype none
// Executes one transfer per item: an instruction word (s_tuser 0) or a load
// return (s_tuser 1), and answers each with one result giving the next fetch
// address and any memory request. An instruction passes through accept,
// register read and execute, and result load; a load return or an instruction
// arriving while a load waits skips the execute step. MULT and DIV run a
// 33-bit add/subtract unit one bit per cycle, then a sign-fix step. The
// register file reads through a registered port, so operands read at accept
// are used in the execute step. s_tready is high only between items; the
// output register holds a finished result while the next item is accepted.
module mips_integer_core_subset (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // [31:0] instr_word, [63:32] load_data
    input  wire [mipsc_pkg::IN_W-1:0]    s_tdata,
    // [0] opcode (0 instruction, 1 load return)
    input  wire [0:0]                    s_tuser,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // [28:0] fetch_addr, [57:29] mem_addr, [89:58] mem_wdata, [90] load_wait
    output logic [mipsc_pkg::OUT_W-1:0]  m_tdata,
    // [1:0] mem_op
    output logic [mipsc_pkg::MOP_W-1:0]  m_tuser
);
    import mipsc_pkg::*;

    state_t state_reg, state_next;

    logic [XLEN-1:0] rf_mem [NREG];
    logic [NREG-1:0] rf_vld_reg;
    logic [XLEN-1:0] rf_a_rdata, rf_b_rdata;
    logic            rf_a_vld_reg, rf_b_vld_reg;
    logic [XLEN-1:0] c0_mem [NREG];
    logic [NREG-1:0] c0_vld_reg;
    logic [XLEN-1:0] c0_rdata;
    logic            c0_vld_reg_rd;

    logic [XLEN-1:0] instr_reg;
    logic [XLEN-1:0] pc_reg, hi_reg, lo_reg, btgt_reg;
    logic            bpend_reg, lpend_reg;
    logic [RIDX_W-1:0] ldest_reg;

    logic [AW-1:0]   res_fa_reg, res_ma_reg;
    logic [MOP_W-1:0] res_mop_reg;
    logic [XLEN-1:0] res_wd_reg;
    logic            res_lw_reg;

    logic            m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;
    logic [MOP_W-1:0] m_tuser_reg;

    logic [63:0]     prod_reg;
    logic [XLEN-1:0] opnd_reg;
    logic            neg_q_reg, neg_r_reg;
    logic [RIDX_W-1:0] cnt_reg;
    logic            cnt_mul_reg;

    // register file write port
    logic              rf_we;
    logic [RIDX_W-1:0] rf_waddr;
    logic [XLEN-1:0]   rf_wdata;

    logic s_fire, kind;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign kind     = s_tuser[0];

    // instruction fields
    logic [5:0]  prim, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] uimm, simm, a, b, c0v, btgt, jtgt, pc4;
    assign prim = instr_reg[31:26];
    assign rs   = instr_reg[25:21];
    assign rt   = instr_reg[20:16];
    assign rd   = instr_reg[15:11];
    assign sh   = instr_reg[10:6];
    assign fn   = instr_reg[5:0];
    assign uimm = {16'h0000, instr_reg[15:0]};
    assign simm = {{16{instr_reg[15]}}, instr_reg[15:0]};
    assign a    = rf_a_vld_reg ? rf_a_rdata : '0;
    assign b    = rf_b_vld_reg ? rf_b_rdata : '0;
    assign c0v  = c0_vld_reg_rd ? c0_rdata : '0;
    assign pc4  = pc_reg + 32'd4;
    assign btgt = pc4 + {simm[29:0], 2'b00};
    assign jtgt = (pc4 & JUMP_MASK) | {4'h0, instr_reg[25:0], 2'b00};

    // execute-cycle decisions
    logic            ex_we;
    logic [4:0]      ex_wa;
    logic [31:0]     ex_wd, ex_ea;
    logic            ex_take, ex_c0we, ex_mul, ex_div;
    logic [1:0]      ex_mop;
    logic [31:0]     ex_tgt;

    always_comb begin
        ex_we   = 1'b0;
        ex_wa   = rd;
        ex_wd   = '0;
        ex_take = 1'b0;
        ex_tgt  = btgt;
        ex_c0we = 1'b0;
        ex_mul  = 1'b0;
        ex_div  = 1'b0;
        ex_mop  = MOP_NONE;
        ex_ea   = a + simm;
        unique case (prim)
            OP_SPECIAL: begin
                unique case (fn)
                    FN_SLL: begin ex_we = 1'b1; ex_wd = b << sh; end
                    FN_SRL: begin ex_we = 1'b1; ex_wd = b >> sh; end
                    FN_SRA: begin ex_we = 1'b1; ex_wd = $unsigned($signed(b) >>> sh); end
                    FN_JR: begin ex_take = 1'b1; ex_tgt = a; end
                    FN_JALR: begin
                        ex_we = 1'b1; ex_wd = pc_reg + 32'd8;
                        ex_take = 1'b1; ex_tgt = a;
                    end
                    FN_MFHI: begin ex_we = 1'b1; ex_wd = hi_reg; end
                    FN_MFLO: begin ex_we = 1'b1; ex_wd = lo_reg; end
                    FN_MULT: ex_mul = 1'b1;
                    FN_DIV:  ex_div = (b != '0);
                    FN_ADD, FN_ADDU: begin ex_we = 1'b1; ex_wd = a + b; end
                    FN_SUB, FN_SUBU: begin ex_we = 1'b1; ex_wd = a - b; end
                    FN_AND: begin ex_we = 1'b1; ex_wd = a & b; end
                    FN_OR:  begin ex_we = 1'b1; ex_wd = a | b; end
                    FN_XOR: begin ex_we = 1'b1; ex_wd = a ^ b; end
                    FN_SLT: begin
                        ex_we = 1'b1; ex_wd = {31'd0, $signed(a) < $signed(b)};
                    end
                    FN_SLTU: begin ex_we = 1'b1; ex_wd = {31'd0, a < b}; end
                    default: ;
                endcase
            end
            OP_REGIMM: ex_take = ((rt == RT_BLTZ) && a[31]) || ((rt == RT_BGEZ) && !a[31]);
            OP_J:   begin ex_take = 1'b1; ex_tgt = jtgt; end
            OP_JAL: begin
                ex_take = 1'b1; ex_tgt = jtgt;
                ex_we = 1'b1; ex_wa = REG_RA; ex_wd = pc_reg + 32'd8;
            end
            OP_BEQ:  ex_take = (a == b);
            OP_BNE:  ex_take = (a != b);
            OP_BLEZ: ex_take = a[31] || (a == '0);
            OP_BGTZ: ex_take = !a[31] && (a != '0);
            OP_ADDI, OP_ADDIU: begin ex_we = 1'b1; ex_wa = rt; ex_wd = a + simm; end
            OP_SLTI: begin
                ex_we = 1'b1; ex_wa = rt; ex_wd = {31'd0, $signed(a) < $signed(simm)};
            end
            OP_SLTIU: begin ex_we = 1'b1; ex_wa = rt; ex_wd = {31'd0, a < simm}; end
            OP_ANDI: begin ex_we = 1'b1; ex_wa = rt; ex_wd = a & uimm; end
            OP_ORI:  begin ex_we = 1'b1; ex_wa = rt; ex_wd = a | uimm; end
            OP_XORI: begin ex_we = 1'b1; ex_wa = rt; ex_wd = a ^ uimm; end
            OP_LUI:  begin ex_we = 1'b1; ex_wa = rt; ex_wd = {instr_reg[15:0], 16'h0000}; end
            OP_COP0: begin
                if (rs == C0_MFC0) begin
                    ex_we = 1'b1; ex_wa = rt; ex_wd = c0v;
                end
                ex_c0we = (rs == C0_MTC0);
            end
            OP_LW: ex_mop = MOP_READ;
            OP_SW: ex_mop = MOP_WRITE;
            default: ;
        endcase
    end

    // shared 33-bit add/subtract step unit
    logic [32:0] alu_x, alu_y, alu_sum;
    logic        alu_cin, div_neg;
    logic [31:0] rem_new;
    always_comb begin
        if (state_reg == ST_DIV) begin
            alu_x   = {prod_reg[63:32], prod_reg[31]};
            alu_y   = ~{1'b0, opnd_reg};
            alu_cin = 1'b1;
        end else begin
            alu_x   = {1'b0, prod_reg[63:32]};
            alu_y   = prod_reg[0] ? {1'b0, opnd_reg} : '0;
            alu_cin = 1'b0;
        end
        alu_sum = alu_x + alu_y + {32'd0, alu_cin};
        div_neg = alu_sum[32];
        rem_new = div_neg ? alu_x[31:0] : alu_sum[31:0];
    end

    logic [31:0] abs_a, abs_b;
    assign abs_a = a[31] ? (~a + 32'd1) : a;
    assign abs_b = b[31] ? (~b + 32'd1) : b;

    logic [63:0] prod_neg;
    logic [31:0] quo_neg, rem_neg;
    assign prod_neg = ~prod_reg + 64'd1;
    assign quo_neg  = ~prod_reg[31:0] + 32'd1;
    assign rem_neg  = ~prod_reg[63:32] + 32'd1;

    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = ex_wa;
        rf_wdata = ex_wd;
        if (s_fire && (kind == KIND_LOAD) && lpend_reg) begin
            rf_we    = (ldest_reg != '0);
            rf_waddr = ldest_reg;
            rf_wdata = s_tdata[63:32];
        end else if (state_reg == ST_EXEC) begin
            rf_we = ex_we && (ex_wa != '0);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_fire) state_next = ((kind == KIND_LOAD) || lpend_reg) ? ST_DONE : ST_EXEC;
            ST_EXEC: state_next = ex_mul ? ST_MUL : (ex_div ? ST_DIV : ST_DONE);
            ST_MUL, ST_DIV: if (cnt_reg == '1) state_next = ST_FIX;
            ST_FIX:  state_next = ST_DONE;
            ST_DONE: if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // memories: registered reads, one write per cycle
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            rf_a_rdata <= rf_mem[s_tdata[25:21]];
            rf_b_rdata <= rf_mem[s_tdata[20:16]];
            c0_rdata   <= c0_mem[s_tdata[15:11]];
        end
        if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
        if ((state_reg == ST_EXEC) && ex_c0we) c0_mem[rd] <= b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rf_vld_reg    <= '0;
            c0_vld_reg    <= '0;
            rf_a_vld_reg  <= 1'b0;
            rf_b_vld_reg  <= 1'b0;
            c0_vld_reg_rd <= 1'b0;
            pc_reg        <= RESET_PC;
            hi_reg        <= '0;
            lo_reg        <= '0;
            btgt_reg      <= '0;
            bpend_reg     <= 1'b0;
            lpend_reg     <= 1'b0;
            ldest_reg     <= '0;
            m_tvalid_reg  <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (rf_we) rf_vld_reg[rf_waddr] <= 1'b1;
            if ((state_reg == ST_EXEC) && ex_c0we) c0_vld_reg[rd] <= 1'b1;
            if (s_fire) begin
                rf_a_vld_reg  <= rf_vld_reg[s_tdata[25:21]];
                rf_b_vld_reg  <= rf_vld_reg[s_tdata[20:16]];
                c0_vld_reg_rd <= c0_vld_reg[s_tdata[15:11]];
                if (kind == KIND_LOAD) lpend_reg <= 1'b0;
            end
            if (state_reg == ST_EXEC) begin
                // a control transfer inside a delay slot is dropped
                bpend_reg <= ex_take && !bpend_reg;
                if (ex_take && !bpend_reg) btgt_reg <= ex_tgt;
                pc_reg <= bpend_reg ? btgt_reg : pc4;
                if (ex_mop == MOP_READ) begin
                    lpend_reg <= 1'b1;
                    ldest_reg <= rt;
                end
                cnt_reg <= '0;
            end
            if ((state_reg == ST_MUL) || (state_reg == ST_DIV)) cnt_reg <= cnt_reg + 5'd1;
            if (state_reg == ST_FIX) begin
                if (cnt_mul_reg) begin
                    hi_reg <= neg_q_reg ? prod_neg[63:32] : prod_reg[63:32];
                    lo_reg <= neg_q_reg ? prod_neg[31:0] : prod_reg[31:0];
                end else begin
                    hi_reg <= neg_r_reg ? rem_neg : prod_reg[63:32];
                    lo_reg <= neg_q_reg ? quo_neg : prod_reg[31:0];
                end
            end
            if (state_reg == ST_DONE) begin
                if (!m_tvalid_reg || m_tready) m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            instr_reg   <= s_tdata[31:0];
            res_fa_reg  <= pc_reg[AW-1:0];
            res_mop_reg <= MOP_NONE;
            res_ma_reg  <= '0;
            res_wd_reg  <= '0;
            res_lw_reg  <= (kind == KIND_INSTR) && lpend_reg;
        end
        if (state_reg == ST_EXEC) begin
            res_fa_reg  <= bpend_reg ? btgt_reg[AW-1:0] : pc4[AW-1:0];
            res_mop_reg <= ex_mop;
            res_ma_reg  <= (ex_mop != MOP_NONE) ? ex_ea[AW-1:0] : '0;
            res_wd_reg  <= (ex_mop == MOP_WRITE) ? b : '0;
            res_lw_reg  <= (ex_mop == MOP_READ);
            cnt_mul_reg <= ex_mul;
            if (ex_mul) begin
                opnd_reg  <= abs_a;
                prod_reg  <= {32'd0, abs_b};
                neg_q_reg <= a[31] ^ b[31];
                neg_r_reg <= 1'b0;
            end else begin
                opnd_reg  <= abs_b;
                prod_reg  <= {32'd0, abs_a};
                neg_q_reg <= a[31] ^ b[31];
                neg_r_reg <= a[31];
            end
        end
        if (state_reg == ST_MUL) prod_reg <= {alu_sum, prod_reg[31:1]};
        if (state_reg == ST_DIV) prod_reg <= {rem_new, prod_reg[30:0], ~div_neg};
        if ((state_reg == ST_DONE) && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= {5'd0, res_lw_reg, res_wd_reg, res_ma_reg, res_fa_reg};
            m_tuser_reg <= res_mop_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
`default_nettype wire

[design/mipsc_checker.sv]
// Port-level checker for the MIPS integer core subset, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module mipsc_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire [mipsc_pkg::IN_W-1:0]    s_tdata,
    input wire [0:0]                    s_tuser,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [mipsc_pkg::OUT_W-1:0]   m_tdata,
    input wire [mipsc_pkg::MOP_W-1:0]   m_tuser
);
    import mipsc_pkg::*;

    logic idle_req;
    assign idle_req = (m_tuser == MOP_NONE);

    `ASSERT_ALWAYS(a_rst_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")
    `ASSERT_CLK(a_mop_legal, aclk, aresetn, m_tvalid |-> (m_tuser != 2'd3), "bad mem_op")
    `ASSERT_CLK(a_none_zero, aclk, aresetn, (m_tvalid && idle_req) |-> (m_tdata[89:29] == '0), "nonzero addr/data with no request")
    `ASSERT_CLK(a_read_wait, aclk, aresetn, (m_tvalid && (m_tuser == MOP_READ)) |-> m_tdata[LW_BIT], "read without load_wait")
    `ASSERT_CLK(a_out_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled result changed")

endmodule

bind mips_integer_core_subset mipsc_checker u_mipsc_checker (.*);
`default_nettype wire

[dv/tb_top.sv]
// Self-checking testbench for the MIPS integer core subset: directed and random instruction streams.
`timescale 1ns / 1ps
module tb_top;
    import mipsc_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int N_RANDOM   = 1400;

    typedef struct {
        logic        kind;
        logic [31:0] word;
        logic [31:0] ldata;
    } core_item_t;

    typedef struct {
        logic [28:0] fetch_addr;
        logic [1:0]  mem_op;
        logic [28:0] mem_addr;
        logic [31:0] mem_wdata;
        logic        load_wait;
    } core_result_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;

    mips_integer_core_subset DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    core_item_t   pending_items[$];
    core_result_t expected_results[$];
    bit           failed = 0;
    bit           burst = 0;

    // architectural state mirror
    logic [31:0] gpr[32];
    logic [31:0] cp0[32];
    logic [31:0] pc, hi, lo, br_target;
    logic        br_pending, ld_pending, slot;
    logic [4:0]  ld_dest;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic write_gpr(input logic [4:0] idx, input logic [31:0] val);
        if (idx != 5'd0) gpr[idx] = val;
    endtask

    task automatic redirect(input logic [31:0] target);
        if (!slot) begin
            br_target  = target;
            br_pending = 1'b1;
        end
    endtask

    task automatic execute_item(input core_item_t it);
        logic [5:0]  prim, fn;
        logic [4:0]  rs, rt, rd, sh;
        logic [31:0] a, b, simm, btgt, jtgt, cur_pc;
        logic [1:0]  mop;
        logic [31:0] maddr, mwdata;
        longint      sa, sb, prod, quo, rem;
        logic        was_slot;
        core_result_t r;
        mop = MOP_NONE;
        maddr = '0;
        mwdata = '0;
        if (it.kind == KIND_LOAD) begin
            if (ld_pending) begin
                write_gpr(ld_dest, it.ldata);
                ld_pending = 1'b0;
            end
        end else if (!ld_pending) begin
            prim = it.word[31:26];
            rs = it.word[25:21];
            rt = it.word[20:16];
            rd = it.word[15:11];
            sh = it.word[10:6];
            fn = it.word[5:0];
            simm = {{16{it.word[15]}}, it.word[15:0]};
            a = gpr[rs];
            b = gpr[rt];
            sa = $signed(a);
            sb = $signed(b);
            cur_pc = pc;
            btgt = cur_pc + 32'd4 + (simm << 2);
            jtgt = ((cur_pc + 32'd4) & JUMP_MASK) | {4'b0, it.word[25:0], 2'b00};
            was_slot = br_pending;
            slot = was_slot;
            br_pending = 1'b0;
            case (prim)
                OP_SPECIAL: begin
                    case (fn)
                        FN_SLL:  write_gpr(rd, b << sh);
                        FN_SRL:  write_gpr(rd, b >> sh);
                        FN_SRA:  write_gpr(rd, $signed(b) >>> sh);
                        FN_JR:   redirect(a);
                        FN_JALR: begin
                            write_gpr(rd, cur_pc + 32'd8);
                            redirect(a);
                        end
                        FN_MFHI: write_gpr(rd, hi);
                        FN_MFLO: write_gpr(rd, lo);
                        FN_MULT: begin
                            prod = sa * sb;
                            lo = prod[31:0];
                            hi = prod[63:32];
                        end
                        FN_DIV: begin
                            if (sb != 0) begin
                                quo = sa / sb;
                                rem = sa % sb;
                                lo = quo[31:0];
                                hi = rem[31:0];
                            end
                        end
                        FN_ADD, FN_ADDU: write_gpr(rd, a + b);
                        FN_SUB, FN_SUBU: write_gpr(rd, a - b);
                        FN_AND:  write_gpr(rd, a & b);
                        FN_OR:   write_gpr(rd, a | b);
                        FN_XOR:  write_gpr(rd, a ^ b);
                        FN_SLT:  write_gpr(rd, {31'b0, sa < sb});
                        FN_SLTU: write_gpr(rd, {31'b0, a < b});
                        default: ;
                    endcase
                end
                OP_REGIMM: begin
                    if (rt == RT_BLTZ && sa < 0) redirect(btgt);
                    else if (rt == RT_BGEZ && sa >= 0) redirect(btgt);
                end
                OP_J:    redirect(jtgt);
                OP_JAL: begin
                    write_gpr(REG_RA, cur_pc + 32'd8);
                    redirect(jtgt);
                end
                OP_BEQ:  if (a == b) redirect(btgt);
                OP_BNE:  if (a != b) redirect(btgt);
                OP_BLEZ: if (sa <= 0) redirect(btgt);
                OP_BGTZ: if (sa > 0) redirect(btgt);
                OP_ADDI, OP_ADDIU: write_gpr(rt, a + simm);
                OP_SLTI:  write_gpr(rt, {31'b0, $signed(a) < $signed(simm)});
                OP_SLTIU: write_gpr(rt, {31'b0, a < simm});
                OP_ANDI:  write_gpr(rt, a & {16'b0, it.word[15:0]});
                OP_ORI:   write_gpr(rt, a | {16'b0, it.word[15:0]});
                OP_XORI:  write_gpr(rt, a ^ {16'b0, it.word[15:0]});
                OP_LUI:   write_gpr(rt, {it.word[15:0], 16'b0});
                OP_COP0: begin
                    if (rs == C0_MFC0) write_gpr(rt, cp0[rd]);
                    else if (rs == C0_MTC0) cp0[rd] = b;
                end
                OP_LW: begin
                    mop = MOP_READ;
                    maddr = a + simm;
                    ld_pending = 1'b1;
                    ld_dest = rt;
                end
                OP_SW: begin
                    mop = MOP_WRITE;
                    maddr = a + simm;
                    mwdata = b;
                end
                default: ;
            endcase
            pc = was_slot ? br_target : cur_pc + 32'd4;
        end
        r.fetch_addr = pc[28:0];
        r.mem_op     = mop;
        r.mem_addr   = maddr[28:0];
        r.mem_wdata  = mwdata;
        r.load_wait  = ld_pending;
        expected_results.push_back(r);
    endtask

    // driver
    int unsigned send_gap = 0;
    always @(posedge aclk) begin : drive_input
        logic       nv;
        core_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            nv = s_tvalid;
            if (s_tvalid && s_tready) begin
                nv = 1'b0;
                send_gap = burst ? 0 : $urandom_range(0, 6);
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_items.size() > 0) begin
                    it = pending_items.pop_front();
                    s_tdata <= {it.ldata, it.word};
                    s_tuser <= it.kind;
                    nv = 1'b1;
                end
            end
            s_tvalid <= nv;
        end
    end

    // prediction on each accepted input transfer
    always @(posedge aclk) begin : predict_input
        core_item_t it;
        if (aresetn && s_tvalid && s_tready) begin
            it.kind  = s_tuser[0];
            it.word  = s_tdata[31:0];
            it.ldata = s_tdata[63:32];
            execute_item(it);
        end
    end

    // monitor
    int unsigned recv_stall = 0;
    always @(posedge aclk) begin : check_output
        core_result_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result with no expectation: %h / %h", m_tdata, m_tuser);
                    failed = 1;
                end else begin
                    e = expected_results.pop_front();
                    if (m_tdata[28:0] !== e.fetch_addr) begin
                        $error("fetch_addr exp %h got %h", e.fetch_addr, m_tdata[28:0]);
                        failed = 1;
                    end
                    if (m_tuser !== e.mem_op) begin
                        $error("mem_op exp %0d got %0d", e.mem_op, m_tuser);
                        failed = 1;
                    end
                    if (m_tdata[57:29] !== e.mem_addr) begin
                        $error("mem_addr exp %h got %h", e.mem_addr, m_tdata[57:29]);
                        failed = 1;
                    end
                    if (m_tdata[89:58] !== e.mem_wdata) begin
                        $error("mem_wdata exp %h got %h", e.mem_wdata, m_tdata[89:58]);
                        failed = 1;
                    end
                    if (m_tdata[90] !== e.load_wait) begin
                        $error("load_wait exp %b got %b", e.load_wait, m_tdata[90]);
                        failed = 1;
                    end
                end
                recv_stall = burst ? 0 : $urandom_range(0, 6);
            end else if (recv_stall > 0) begin
                recv_stall--;
            end
            m_tready <= (recv_stall == 0);
        end
    end

    // watchdog: cycles with no transfer on either side
    int unsigned idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("mips_integer_core_subset: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) if ($urandom_range(0, 99) == 0) burst <= ~burst;

    function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [4:0] pick_reg();
        return $urandom_range(0, 1) ? 5'($urandom_range(0, 7)) : 5'($urandom_range(0, 31));
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [5:0] rfn[18] = '{FN_SLL, FN_SRL, FN_SRA, FN_JR, FN_JALR, FN_MFHI, FN_MFLO,
                                FN_MULT, FN_DIV, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND,
                                FN_OR, FN_XOR, FN_SLT, FN_SLTU};
        logic [5:0] iop[18] = '{OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI,
                                OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LUI, OP_ORI,
                                OP_LW, OP_SW, OP_LW, OP_SW};
        logic [4:0] sub;
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                return enc_r(rfn[$urandom_range(0, 17)], pick_reg(), pick_reg(), pick_reg(),
                             5'($urandom));
            4, 5, 6, 7:
                return enc_i(iop[$urandom_range(0, 17)], pick_reg(), pick_reg(), pick_imm());
            8: begin
                sub = $urandom_range(0, 3) != 0 ? 5'($urandom_range(0, 1)) : 5'($urandom);
                return $urandom_range(0, 1) ? enc_i(OP_REGIMM, pick_reg(), sub, pick_imm())
                                            : {$urandom_range(0, 1) ? OP_J : OP_JAL,
                                               26'($urandom)};
            end
            default: begin
                sub = $urandom_range(0, 3) == 0 ? 5'($urandom)
                    : ($urandom_range(0, 1) ? C0_MFC0 : C0_MTC0);
                return {OP_COP0, sub, pick_reg(), 5'($urandom), 11'b0};
            end
        endcase
    endfunction

    task automatic add_instr(input logic [31:0] w);
        core_item_t it;
        it.kind = KIND_INSTR;
        it.word = w;
        it.ldata = $urandom;
        pending_items.push_back(it);
    endtask

    task automatic add_return(input logic [31:0] d);
        core_item_t it;
        it.kind = KIND_LOAD;
        it.word = $urandom;
        it.ldata = d;
        pending_items.push_back(it);
    endtask

    initial begin
        logic [31:0] w;
        for (int i = 0; i < 32; i++) begin
            gpr[i] = '0;
            cp0[i] = '0;
        end
        pc = RESET_PC;
        hi = '0;
        lo = '0;
        br_target = '0;
        br_pending = 1'b0;
        ld_pending = 1'b0;
        ld_dest = '0;
        slot = 1'b0;

        // directed: extremes, arithmetic corners, delay-slot and load cases
        add_instr(enc_i(OP_LUI, 5'd0, 5'd1, 16'h8000));
        add_instr(enc_i(OP_ADDIU, 5'd0, 5'd3, 16'hFFFF));
        add_instr(enc_i(OP_ORI, 5'd0, 5'd2, 16'hFFFF));
        add_instr(enc_r(FN_MULT, 5'd1, 5'd3, 5'd0, 5'd0));
        add_instr(enc_r(FN_MFHI, 5'd0, 5'd0, 5'd4, 5'd0));
        add_instr(enc_r(FN_DIV, 5'd1, 5'd3, 5'd0, 5'd0));    // INT_MIN / -1
        add_instr(enc_r(FN_MFLO, 5'd0, 5'd0, 5'd5, 5'd0));
        add_instr(enc_r(FN_DIV, 5'd2, 5'd0, 5'd0, 5'd0));    // by zero
        add_instr(enc_r(FN_SRA, 5'd0, 5'd1, 5'd6, 5'd31));
        add_instr(enc_r(FN_SLT, 5'd1, 5'd2, 5'd7, 5'd0));
        add_instr(enc_r(FN_SLTU, 5'd1, 5'd2, 5'd8, 5'd0));
        add_instr(enc_r(FN_ADDU, 5'd3, 5'd3, 5'd0, 5'd0));   // write to r0 dropped
        add_instr(enc_i(OP_BEQ, 5'd0, 5'd0, 16'h0010));
        add_instr({OP_JAL, 26'h3FFFFFF});                    // jump in a delay slot
        add_instr(enc_r(FN_JALR, 5'd31, 5'd0, 5'd31, 5'd0)); // rd == rs
        add_instr(enc_i(OP_COP0, C0_MTC0, 5'd3, 16'hF800));
        add_instr(enc_i(OP_COP0, C0_MFC0, 5'd9, 16'hF800));
        add_instr(enc_i(OP_LW, 5'd3, 5'd10, 16'h8000));
        add_instr(32'hFFFF_FFFF);                            // ignored while load waits
        add_return(32'hFFFF_FFFF);
        add_return(32'h1234_5678);                           // stray return
        add_instr(enc_i(OP_SW, 5'd1, 5'd10, 16'h7FFF));
        add_instr(enc_i(OP_REGIMM, 5'd1, RT_BLTZ, 16'hFFFF));
        add_instr(enc_i(OP_BGTZ, 5'd2, 5'd0, 16'h0000));
        add_instr({6'h3F, 26'h0});                           // unknown opcode

        for (int n = 0; n < N_RANDOM; n++) begin
            case ($urandom_range(0, 99))
                0, 1, 2: add_return($urandom);
                3, 4, 5, 6, 7: add_instr($urandom);
                default: begin
                    w = rand_instr();
                    add_instr(w);
                    if (w[31:26] == OP_LW) begin
                        if ($urandom_range(0, 9) == 0) add_instr($urandom);
                        if ($urandom_range(0, 19) != 0) add_return($urandom);
                    end
                end
            endcase
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (!failed)
            $display("mips_integer_core_subset: match");
        else
            $display("mips_integer_core_subset: mismatch");
        $finish;
    end
endmodule

[files.f]
+incdir+design
design/mipsc_pkg.sv
design/mips_integer_core_subset.sv
design/mipsc_checker.sv
dv/tb_top.sv
